// File: rtl/dfhe_pkg.sv
package dfhe_pkg;

  // Token commands on the input channel
  localparam logic [1:0] CMD_LITERAL = 2'd0;
  localparam logic [1:0] CMD_MATCH   = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;   // no meaning, dropped

  // Classified token kind, as queued between front and back
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_FINISH,
    KIND_ERROR
  } tok_kind_t;

  // Longest bit run of one token: header 3 + length code 8 + extra 5
  // + distance code 5 + extra 13
  localparam int unsigned TOK_BITS = 34;
  localparam int unsigned TOK_CNT_W = 6;

  typedef struct packed {
    tok_kind_t              kind;
    logic [TOK_BITS-1:0]    bits;   // LSB is sent first, zero above nbits
    logic [TOK_CNT_W-1:0]   nbits;
  } tok_t;

endpackage

// File: rtl/dfhe_front.sv
module dfhe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [7:0]          literal,
  input  logic [8:0]          match_length,
  input  logic [15:0]         match_distance,
  input  logic                q_full,
  output logic                q_push,
  output dfhe_pkg::tok_t      q_tok
);

  localparam logic [8:0] LEN_BASE [29] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };
  localparam logic [2:0] LEN_XBITS [29] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0
  };
  localparam logic [15:0] DIST_BASE [30] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
    16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
    16'd8193, 16'd12289, 16'd16385, 16'd24577
  };
  localparam logic [3:0] DIST_XBITS [30] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  // Huffman codes go out MSB first: reverse the n-bit code into LSB-first order
  function automatic logic [8:0] rev_code(input logic [8:0] v, input logic [3:0] n);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = v[8-i];
    end
    return r >> (4'd9 - n);
  endfunction

  logic                           hdr_sent;
  logic                           accept;
  logic                           bad;
  logic [4:0]                     li;
  logic [4:0]                     di;
  logic [8:0]                     len_ext;
  logic [15:0]                    dist_ext;
  logic [8:0]                     code;
  logic [3:0]                     code_len;
  logic [dfhe_pkg::TOK_BITS-1:0]  bits;
  logic [dfhe_pkg::TOK_CNT_W-1:0] pos;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (cmd != dfhe_pkg::CMD_SPARE);

  assign bad = (cmd == dfhe_pkg::CMD_MATCH) &&
               ((match_length < 9'd3) || (match_length > 9'd258) ||
                (match_distance == 16'd0) || (match_distance > 16'd32768));

  // bucket search: tables are monotonic, last hit wins
  always_comb begin
    li = '0;
    for (int i = 1; i < 29; i++) begin
      if (match_length >= LEN_BASE[i]) li = 5'(i);
    end
    di = '0;
    for (int i = 1; i < 30; i++) begin
      if (match_distance >= DIST_BASE[i]) di = 5'(i);
    end
  end

  assign len_ext  = match_length - LEN_BASE[li];
  assign dist_ext = match_distance - DIST_BASE[di];

  always_comb begin
    if (cmd == dfhe_pkg::CMD_LITERAL) begin
      if (literal <= 8'd143) begin
        code     = 9'h030 + 9'(literal);
        code_len = 4'd8;
      end else begin
        code     = 9'h190 + 9'(literal - 8'd144);
        code_len = 4'd9;
      end
    end else if (cmd == dfhe_pkg::CMD_MATCH) begin
      // symbols 257..279 are 7 bits, 280..285 are 8 bits
      if (li <= 5'd22) begin
        code     = 9'(li) + 9'd1;
        code_len = 4'd7;
      end else begin
        code     = 9'h0C0 + 9'(li - 5'd23);
        code_len = 4'd8;
      end
    end else begin
      code     = 9'd0;  // end of block
      code_len = 4'd7;
    end
  end

  // assemble the token's bit run, LSB first
  always_comb begin
    bits = '0;
    pos  = '0;
    if (!hdr_sent) begin
      bits = dfhe_pkg::TOK_BITS'(3);   // BFINAL=1, BTYPE=01
      pos  = 6'd3;
    end
    bits = bits | (dfhe_pkg::TOK_BITS'(rev_code(code, code_len)) << pos);
    pos  = pos + 6'(code_len);
    if (cmd == dfhe_pkg::CMD_MATCH) begin
      bits = bits | (dfhe_pkg::TOK_BITS'(len_ext[4:0]) << pos);
      pos  = pos + 6'(LEN_XBITS[li]);
      bits = bits | (dfhe_pkg::TOK_BITS'({di[0], di[1], di[2], di[3], di[4]}) << pos);
      pos  = pos + 6'd5;
      bits = bits | (dfhe_pkg::TOK_BITS'(dist_ext[12:0]) << pos);
      pos  = pos + 6'(DIST_XBITS[di]);
    end
  end

  always_comb begin
    q_tok.bits  = bits;
    q_tok.nbits = pos;
    q_tok.kind  = dfhe_pkg::KIND_DATA;
    if (bad) begin
      q_tok.kind  = dfhe_pkg::KIND_ERROR;
      q_tok.bits  = '0;
      q_tok.nbits = '0;
    end else if (cmd == dfhe_pkg::CMD_FINISH) begin
      q_tok.kind = dfhe_pkg::KIND_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_sent <= 1'b0;
    end else if (q_push && !bad) begin
      hdr_sent <= (cmd != dfhe_pkg::CMD_FINISH);
    end
  end

endmodule

// File: rtl/dfhe_fifo.sv
module dfhe_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfhe_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dfhe_pkg::tok_t head
);

  dfhe_pkg::tok_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/dfhe_back.sv
module dfhe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  dfhe_pkg::tok_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           run_last,
  output logic           stream_end,
  output logic           bad_token
);

  localparam int unsigned WORK_W = dfhe_pkg::TOK_BITS + 7;

  logic                           busy;
  logic [WORK_W-1:0]              work;
  logic [dfhe_pkg::TOK_CNT_W-1:0] wcnt;
  dfhe_pkg::tok_kind_t            wkind;
  logic [6:0]                     pend;
  logic [2:0]                     pcnt;

  logic [WORK_W-1:0]              cw;
  logic [dfhe_pkg::TOK_CNT_W-1:0] cc;
  logic [dfhe_pkg::TOK_CNT_W-1:0] rem;
  dfhe_pkg::tok_kind_t            ck;
  logic                           act;
  logic                           need;
  logic                           last;
  logic                           can_emit;
  logic                           emit;
  logic                           take;

  // current word: held remainder, or queue head merged behind pending bits
  always_comb begin
    if (busy) begin
      cw  = work;
      cc  = wcnt;
      ck  = wkind;
      act = 1'b1;
    end else begin
      cw  = (WORK_W'(head.bits) << pcnt) | WORK_W'(pend);
      cc  = head.nbits + dfhe_pkg::TOK_CNT_W'(pcnt);
      ck  = head.kind;
      act = head_valid;
    end
  end

  always_comb begin
    rem  = (cc >= 6'd8) ? (cc - 6'd8) : 6'd0;
    need = 1'b1;
    last = 1'b1;
    case (ck)
      dfhe_pkg::KIND_DATA: begin
        need = (cc >= 6'd8);
        last = (rem < 6'd8);
      end
      dfhe_pkg::KIND_FINISH: last = (cc <= 6'd8);
      default:               last = 1'b1;
    endcase
  end

  assign can_emit = !out_valid || !out_stall;
  assign emit     = act && need && can_emit;
  assign take     = act && (!need || can_emit);
  assign pop      = take && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= '0;
      pcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_emit) out_valid <= emit;
      if (emit) begin
        out_byte   <= (ck == dfhe_pkg::KIND_ERROR) ? 8'd0 : cw[7:0];
        run_last   <= last;
        stream_end <= last && (ck == dfhe_pkg::KIND_FINISH);
        bad_token  <= (ck == dfhe_pkg::KIND_ERROR);
      end
      if (take) begin
        if (!need) begin
          pend <= cw[6:0];
          pcnt <= cc[2:0];
        end else if (last) begin
          busy <= 1'b0;
          if (ck == dfhe_pkg::KIND_DATA) begin
            pend <= cw[14:8];
            pcnt <= rem[2:0];
          end else if (ck == dfhe_pkg::KIND_FINISH) begin
            pend <= '0;
            pcnt <= '0;
          end
        end else begin
          busy  <= 1'b1;
          work  <= cw >> 8;
          wcnt  <= rem;
          wkind <= ck;
        end
      end
    end
  end

endmodule

// File: rtl/deflate_fixed_huffman_encoder.sv
// Fixed-Huffman DEFLATE encoder: LZ77 tokens in, packed bytes out (LSB first).
// The first byte of a token passes through the token queue and then the output register.
// Throughput: one byte per cycle from the bit packer while out_stall is low; a token
// gives up to 5 bytes from a match, 1 to 2 from a literal. A 2-entry queue decouples input.
// Reset (rst, synchronous): queue empty, no pending bits, header due again.
module deflate_fixed_huffman_encoder (
  input  logic        clk,
  input  logic        rst,
  // token input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  literal,
  input  logic [8:0]  match_length,
  input  logic [15:0] match_distance,
  // byte output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_end,
  output logic        bad_token
);

  // Front: validates each token, maps it to its fixed code, extra bits and
  // distance code, and prepends the block header when one is due. The whole
  // token becomes a single LSB-first bit run of up to 34 bits.
  logic           q_full;
  logic           q_push;
  dfhe_pkg::tok_t q_tok;

  dfhe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .literal        (literal),
    .match_length   (match_length),
    .match_distance (match_distance),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_tok          (q_tok)
  );

  // Token queue: lets the front keep taking transfers while the packer
  // drains a long match or the output side stalls.
  logic           q_pop;
  logic           q_head_valid;
  dfhe_pkg::tok_t q_head;

  dfhe_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_tok   (q_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back: bit packer. Merges each run behind the pending bits and sends one
  // byte per cycle through the output register while out_stall is low; a finish
  // pads and closes the stream, a bad match yields a single error byte.
  dfhe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end),
    .bad_token  (bad_token)
  );

endmodule
